FILE: sv/mtdc_pkg.sv
// ----------------------------------------------------------------------------
// mtdc_pkg
// shared types and constants of the multi-track delay compensation unit
// ----------------------------------------------------------------------------
package mtdc_pkg;

    localparam int TRACKS       = 16;
    localparam int MAX_DELAY    = 1024;
    localparam int SAMPLE_WIDTH = 32;

    localparam int TRACK_W = $clog2(TRACKS);
    localparam int DELAY_W = $clog2(MAX_DELAY);
    localparam int CAP_W   = DELAY_W + 1;
    localparam int COUNT_W = 5;
    localparam int LAT_IN_W = 11;
    localparam int ADDR_W  = TRACK_W + DELAY_W;

    localparam logic OP_SET     = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    localparam logic REG_TRACK_COUNT     = 1'b0;
    localparam logic REG_COMPENSATION_ON = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MAX,
        S_DELAY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mem_access;
        logic max_step;
        logic delay_step;
        logic out_fire;
    } t_cmd;

    typedef struct packed {
        logic is_set;
        logic active;
        logic ring_on;
        logic idx_last;
    } t_status;

endpackage

FILE: sv/mtdc_ctrl.sv
// ----------------------------------------------------------------------------
// mtdc_ctrl
// controller: sequences capture, ring access, latency scan and result strobe
// ----------------------------------------------------------------------------
module mtdc_ctrl import mtdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_status.is_set && i_status.active) n_state = S_MAX;
                else n_state = S_OUT;
            end
            S_MAX: begin
                if (i_status.idx_last) n_state = S_DELAY;
            end
            S_DELAY: begin
                if (i_status.idx_last) n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            S_DISPATCH: begin
                o_cmd.mem_access = i_status.ring_on;
            end
            S_MAX: begin
                o_cmd.max_step = 1'b1;
            end
            S_DELAY: begin
                o_cmd.delay_step = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_fire = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: sv/mtdc_datapath.sv
// ----------------------------------------------------------------------------
// mtdc_datapath
// track tables, latency scan, ring memory and result formatting
// ----------------------------------------------------------------------------
module mtdc_datapath import mtdc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [COUNT_W-1:0]      i_cfg_data,
    input  logic                    i_operation,
    input  logic [TRACK_W-1:0]      i_track,
    input  logic signed [LAT_IN_W-1:0] i_latency,
    input  logic [31:0]             i_sample_in,
    input  logic                    i_block_end,
    output logic [31:0]             o_sample_out,
    output logic [DELAY_W-1:0]      o_track_delay,
    output logic [DELAY_W-1:0]      o_peak_latency,
    output logic                    o_block_end_out
);

    logic [COUNT_W-1:0] r_track_count;
    logic               r_comp_on;

    logic [DELAY_W-1:0] r_lat   [TRACKS];
    logic [DELAY_W-1:0] r_delay [TRACKS];
    logic [CAP_W-1:0]   r_cap   [TRACKS];
    logic [DELAY_W-1:0] r_wpos  [TRACKS];
    logic [CAP_W-1:0]   r_fill  [TRACKS];
    logic [DELAY_W-1:0] r_largest;

    logic                    r_op;
    logic [TRACK_W-1:0]      r_track;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_be;
    logic [TRACK_W-1:0]      r_idx;
    logic [DELAY_W-1:0]      r_acc;
    logic                    r_rd_valid;

    logic [SAMPLE_WIDTH-1:0] r_mem [TRACKS*MAX_DELAY];
    logic [SAMPLE_WIDTH-1:0] r_mem_q;

    logic               scan;
    logic [TRACK_W-1:0] sel;
    logic [DELAY_W-1:0] sel_lat;
    logic [DELAY_W-1:0] sel_delay;
    logic [CAP_W-1:0]   sel_cap;
    logic [DELAY_W-1:0] sel_wpos;
    logic [CAP_W-1:0]   sel_fill;
    logic               active;
    logic               in_active;
    logic [DELAY_W-1:0] in_lat;
    logic [CAP_W-1:0]   rd_wide;
    logic [DELAY_W-1:0] rd;
    logic [CAP_W-1:0]   pos_inc;
    logic [DELAY_W-1:0] need;
    logic [CAP_W-1:0]   need_cap;
    logic [COUNT_W-1:0] idx_inc;

    assign scan      = i_cmd.max_step | i_cmd.delay_step;
    assign sel       = scan ? r_idx : r_track;
    assign sel_lat   = r_lat[sel];
    assign sel_delay = r_delay[sel];
    assign sel_cap   = r_cap[sel];
    assign sel_wpos  = r_wpos[sel];
    assign sel_fill  = r_fill[sel];

    assign active    = {1'b0, r_track} < r_track_count;
    assign in_active = {1'b0, i_track} < r_track_count;
    assign in_lat    = i_latency[LAT_IN_W-1] ? '0 : i_latency[DELAY_W-1:0];

    assign rd_wide = ({1'b0, sel_wpos} >= {1'b0, sel_delay})
                   ? {1'b0, sel_wpos} - {1'b0, sel_delay}
                   : {1'b0, sel_wpos} + sel_cap - {1'b0, sel_delay};
    assign rd      = rd_wide[DELAY_W-1:0];
    assign pos_inc = {1'b0, sel_wpos} + CAP_W'(1);

    assign need     = r_acc - sel_lat;
    assign need_cap = {1'b0, need} + CAP_W'(1);
    assign idx_inc  = {1'b0, r_idx} + COUNT_W'(1);

    assign o_status.is_set   = (r_op == OP_SET);
    assign o_status.active   = active;
    assign o_status.ring_on  = (r_op == OP_PROCESS) && active && r_comp_on
                             && (sel_delay != '0);
    assign o_status.idx_last = (idx_inc == r_track_count) || (r_idx == TRACK_W'(TRACKS-1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= COUNT_W'(TRACKS);
            r_comp_on     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRACK_COUNT:     r_track_count <= i_cfg_data;
                REG_COMPENSATION_ON: r_comp_on     <= i_cfg_data[0];
                default:             r_comp_on     <= r_comp_on;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TRACKS; i++) begin
                r_lat[i]   <= '0;
                r_delay[i] <= '0;
                r_cap[i]   <= '0;
                r_wpos[i]  <= '0;
                r_fill[i]  <= '0;
            end
            r_largest <= '0;
            r_idx     <= '0;
            r_acc     <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_idx <= '0;
                r_acc <= '0;
                if (i_operation == OP_SET && in_active) r_lat[i_track] <= in_lat;
            end
            if (i_cmd.mem_access) begin
                r_wpos[sel] <= (pos_inc == sel_cap) ? '0 : pos_inc[DELAY_W-1:0];
                if (sel_fill < sel_cap) r_fill[sel] <= sel_fill + CAP_W'(1);
            end
            if (i_cmd.max_step) begin
                if (sel_lat > r_acc) r_acc <= sel_lat;
                r_idx <= o_status.idx_last ? '0 : idx_inc[TRACK_W-1:0];
            end
            if (i_cmd.delay_step) begin
                r_largest    <= r_acc;
                r_delay[sel] <= need;
                if (need_cap > sel_cap) begin
                    r_cap[sel]  <= need_cap;
                    r_wpos[sel] <= '0;
                    r_fill[sel] <= '0;
                end
                r_idx <= idx_inc[TRACK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_track  <= i_track;
            r_sample <= i_sample_in[SAMPLE_WIDTH-1:0];
            r_be     <= i_block_end;
        end
        if (i_cmd.mem_access) begin
            r_rd_valid <= {1'b0, rd} < sel_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_access) begin
            r_mem[{sel, sel_wpos}] <= r_sample;
            r_mem_q                <= r_mem[{sel, rd}];
        end
    end

    logic r_ring_used;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_ring_used <= 1'b0;
        else if (i_cmd.mem_access) r_ring_used <= 1'b1;
    end

    always_comb begin
        if (r_op == OP_SET) o_sample_out = '0;
        else if (r_ring_used) o_sample_out = r_rd_valid ? 32'(r_mem_q) : '0;
        else o_sample_out = 32'(r_sample);
    end

    assign o_track_delay   = active ? sel_delay : '0;
    assign o_peak_latency  = r_largest;
    assign o_block_end_out = r_be;

endmodule

FILE: sv/multi_track_delay_compensation_unit.sv
// ----------------------------------------------------------------------------
// multi_track_delay_compensation_unit
// Per-track latency compensation. An item is taken when start is high and
// busy is low; its result appears for exactly one cycle with o_result_valid
// and cannot be stalled. A sample item passes through capture, one ring
// memory write plus read (on an active, compensated track with nonzero
// delay only) and result. A latency-set item on an active track adds two
// serial passes over the track table (maximum search, then delay update)
// before the result. Rings need no clearing pass: a per-track fill count
// masks entries not yet written, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module multi_track_delay_compensation_unit import mtdc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [COUNT_W-1:0]         i_cfg_data,
    input  logic                       i_operation,
    input  logic [3:0]                 i_track,
    input  logic signed [10:0]         i_latency,
    input  logic [31:0]                i_sample_in,
    input  logic                       i_block_end,
    output logic                       o_result_valid,
    output logic [31:0]                o_sample_out,
    output logic [9:0]                 o_track_delay,
    output logic [9:0]                 o_peak_latency,
    output logic                       o_block_end_out
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = cmd.out_fire;

    mtdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    mtdc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_track         (i_track),
        .i_latency       (i_latency),
        .i_sample_in     (i_sample_in),
        .i_block_end     (i_block_end),
        .o_sample_out    (o_sample_out),
        .o_track_delay   (o_track_delay),
        .o_peak_latency  (o_peak_latency),
        .o_block_end_out (o_block_end_out)
    );

endmodule

FILE: test/multi_track_delay_compensation_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_track_delay_compensation_unit_test
// Drives latency-set and sample transactions into the delay compensation
// unit under several track counts and with compensation on and off. A
// software copy of the latency, delay and ring tables works out each
// expected result, and every result strobe is compared field by field.
// ----------------------------------------------------------------------------
module multi_track_delay_compensation_unit_test;
    import mtdc_pkg::*;

    typedef struct {
        logic [31:0] sample;
        logic [9:0]  delay;
        logic [9:0]  max_lat;
        logic        blk_end;
    } t_comp_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = REG_TRACK_COUNT;
    logic [COUNT_W-1:0] i_cfg_data = '0;
    logic              i_operation = OP_SET;
    logic [3:0]        i_track = '0;
    logic signed [10:0] i_latency = '0;
    logic [31:0]       i_sample_in = '0;
    logic              i_block_end = 1'b0;
    logic              o_result_valid;
    logic [31:0]       o_sample_out;
    logic [9:0]        o_track_delay;
    logic [9:0]        o_peak_latency;
    logic              o_block_end_out;

    multi_track_delay_compensation_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned       active_count;
    bit                comp_enabled;
    bit [9:0]          lat_tab [TRACKS];
    bit [9:0]          delay_tab [TRACKS];
    int unsigned       ring_cap [TRACKS];
    int unsigned       wr_pos [TRACKS];
    bit [9:0]          largest_lat;
    bit [31:0]         ring_mem [TRACKS][MAX_DELAY];

    t_comp_result      pending_results [$];
    int unsigned       errors = 0;
    int unsigned       checked = 0;
    int unsigned       sets_sent = 0;
    int unsigned       samples_sent = 0;
    int unsigned       cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("multi_track_delay_compensation_unit_test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_comp_result exp_r;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result sample=%h", $time, o_sample_out);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                checked++;
                if (o_sample_out !== exp_r.sample) begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, exp_r.sample, o_sample_out);
                    errors++;
                end
                if (o_track_delay !== exp_r.delay) begin
                    $display("%0t: track_delay expected %0d actual %0d",
                             $time, exp_r.delay, o_track_delay);
                    errors++;
                end
                if (o_peak_latency !== exp_r.max_lat) begin
                    $display("%0t: peak_latency expected %0d actual %0d",
                             $time, exp_r.max_lat, o_peak_latency);
                    errors++;
                end
                if (o_block_end_out !== exp_r.blk_end) begin
                    $display("%0t: block_end_out expected %b actual %b",
                             $time, exp_r.blk_end, o_block_end_out);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned live_tracks();
        return (active_count > TRACKS) ? TRACKS : active_count;
    endfunction

    function automatic void update_delays();
        int unsigned n;
        int unsigned need;
        n = live_tracks();
        largest_lat = '0;
        for (int i = 0; i < n; i++)
            if (lat_tab[i] > largest_lat) largest_lat = lat_tab[i];
        for (int i = 0; i < n; i++) begin
            need = largest_lat - lat_tab[i];
            delay_tab[i] = 10'(need);
            if (need + 1 > ring_cap[i]) begin
                ring_cap[i] = need + 1;
                wr_pos[i] = 0;
                for (int k = 0; k < MAX_DELAY; k++) ring_mem[i][k] = '0;
            end
        end
    endfunction

    function automatic t_comp_result compensate(logic op, logic [3:0] trk,
                                                logic signed [10:0] lat,
                                                logic [31:0] smp, logic be);
        t_comp_result r;
        bit           is_active;
        int unsigned  cap;
        int unsigned  pos;
        int unsigned  d;
        int unsigned  rd;
        is_active = trk < live_tracks();
        r.sample = '0;
        if (op == OP_SET) begin
            if (is_active) begin
                lat_tab[trk] = lat[10] ? 10'd0 : lat[9:0];
                update_delays();
            end
        end else begin
            r.sample = smp;
            if (is_active && comp_enabled && delay_tab[trk] != 0) begin
                cap = ring_cap[trk];
                pos = wr_pos[trk];
                d = delay_tab[trk];
                if (cap == 0 || cap > MAX_DELAY) cap = MAX_DELAY;
                if (pos >= cap) pos = 0;
                if (d >= cap) d = cap - 1;
                ring_mem[trk][pos] = smp;
                rd = (pos >= d) ? pos - d : pos + cap - d;
                r.sample = ring_mem[trk][rd];
                pos++;
                if (pos >= cap) pos = 0;
                wr_pos[trk] = pos;
            end
        end
        r.delay = is_active ? delay_tab[trk] : 10'd0;
        r.max_lat = largest_lat;
        r.blk_end = be;
        return r;
    endfunction

    // called right after a rising edge; returns at the edge that takes the item
    task automatic send_item(logic op, logic [3:0] trk, logic signed [10:0] lat,
                             logic [31:0] smp, logic be);
        i_operation <= op;
        i_track <= trk;
        i_latency <= lat;
        i_sample_in <= smp;
        i_block_end <= be;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(compensate(op, trk, lat, smp, be));
        if (op == OP_SET) sets_sent++;
        else samples_sent++;
    endtask

    task automatic pause(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3 + 2 * TRACKS + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [COUNT_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_TRACK_COUNT) active_count = val;
        else comp_enabled = val[0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(OP_PROCESS, 4'd0, 11'sd0, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_SET, 4'd3, 11'sd1023, 32'h0, 1'b0);
        send_item(OP_SET, 4'd5, -11'sd1024, 32'h0, 1'b1);
        send_item(OP_SET, 4'd5, -11'sd1, 32'h0, 1'b0);
        send_item(OP_SET, 4'd15, 11'sd4, 32'h0, 1'b0);
        send_item(OP_PROCESS, 4'd15, 11'sd0, 32'hA5A5_5A5A, 1'b0);
        send_item(OP_PROCESS, 4'd3, 11'sd0, 32'h1234_5678, 1'b0);
        for (int i = 0; i < 6; i++)
            send_item(OP_PROCESS, 4'd0, -11'sd1, $urandom, 1'(i == 5));
        send_item(OP_SET, 4'd3, 11'sd2, 32'h0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_item(OP_PROCESS, 4'd1, 11'sd0, $urandom, 1'b0);
        send_item(OP_SET, 4'd0, 11'sd1022, 32'h0, 1'b0);
        send_item(OP_PROCESS, 4'd2, 11'sd0, 32'h0000_0000, 1'b1);
        write_reg(REG_TRACK_COUNT, 5'd2);
        send_item(OP_SET, 4'd7, 11'sd9, 32'h0, 1'b0);
        send_item(OP_PROCESS, 4'd7, 11'sd0, 32'hDEAD_BEEF, 1'b0);
        write_reg(REG_TRACK_COUNT, 5'd0);
        send_item(OP_SET, 4'd0, 11'sd7, 32'h0, 1'b0);
        send_item(OP_PROCESS, 4'd0, 11'sd0, 32'h0BAD_F00D, 1'b0);
        write_reg(REG_TRACK_COUNT, 5'd16);
        send_item(OP_PROCESS, 4'd1, 11'sd0, 32'h5555_AAAA, 1'b0);
    endtask

    task automatic test_random(int unsigned n_items, logic [COUNT_W-1:0] count,
                               bit enable);
        int unsigned burst;
        logic        op;
        logic signed [10:0] lat;
        write_reg(REG_TRACK_COUNT, count);
        write_reg(REG_COMPENSATION_ON, COUNT_W'(enable));
        burst = $urandom_range(1, 30);
        for (int i = 0; i < n_items; i++) begin
            op = ($urandom_range(0, 9) == 0) ? OP_SET : OP_PROCESS;
            case ($urandom_range(0, 9))
                0: lat = 11'($urandom);
                1: lat = -$signed(11'($urandom_range(1, 1024)));
                default: lat = 11'($urandom_range(0, 12));
            endcase
            send_item(op, 4'($urandom_range(0, 15)), lat, $urandom,
                      1'($urandom_range(0, 1)));
            if (--burst == 0) begin
                if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    initial begin
        active_count = 16;
        comp_enabled = 1'b1;
        largest_lat = '0;
        for (int i = 0; i < TRACKS; i++) begin
            lat_tab[i] = '0;
            delay_tab[i] = '0;
            ring_cap[i] = 0;
            wr_pos[i] = 0;
            for (int k = 0; k < MAX_DELAY; k++) ring_mem[i][k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500, 5'd16, 1'b1);
        test_random(250, 5'd1, 1'b1);
        test_random(150, 5'd0, 1'b1);
        test_random(250, 5'd7, 1'b0);
        test_random(250, 5'd31, 1'b1);
        test_random(300, 5'd4, 1'b1);
        wait_idle();
        $display("covered %0d latency-set and %0d sample transactions, %0d results checked",
                 sets_sent, samples_sent, checked);
        $display("track counts 0 to 31, compensation on and off, %0d mismatches", errors);
        if (errors == 0) begin
            $display("multi_track_delay_compensation_unit_test passed");
        end else begin
            $display("multi_track_delay_compensation_unit_test failed");
        end
        $finish;
    end

endmodule
